FILE: rtl/core/mlfb_pkg.sv
// shared constants, types and address helpers for the monochrome lcd frame store
// used by mono_lcd_framebuffer_engine and mlfb_refresh; depends on nothing
package mlfb_pkg;

   localparam int COLUMNS   = 128;
   localparam int PAGES     = 8;
   localparam int ROWS      = PAGES * 8;
   localparam int MEM_DEPTH = COLUMNS * PAGES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int OFF_LAST  = COLUMNS + 2;
   localparam int OFF_W     = $clog2(COLUMNS + 3);

   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_LO = 8'h00;
   localparam logic [7:0] CMD_COL_HI = 8'h10;

   typedef enum logic [1:0] {
      OP_POINT = 2'd0,
      OP_FILL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_PULL  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_CLEAR,
      ST_RESP
   } st_type;

   // current refresh byte as seen by the control logic
   typedef struct packed {
      logic              is_data;
      logic [7:0]        cmd_byte;
      logic              last;
      logic [ADDR_W-1:0] addr;
   } rfr_type;

   // store index of column byte col in page page
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [COL_W-1:0]  col,
                                                  input logic [PAGE_W-1:0] page);
      mem_addr = ADDR_W'(ADDR_W'(col) * ADDR_W'(PAGES)) + ADDR_W'(page);
   endfunction

   // row group (row / 8) to page number, top group lands in the last page
   function automatic logic [PAGE_W-1:0] page_of(input logic [PAGE_W-1:0] grp);
      page_of = PAGE_W'(PAGES - 1) - grp;
   endfunction

endpackage

FILE: rtl/core/mono_lcd_framebuffer_engine.sv
// point draw and refresh pull read the store on acceptance, then in the response state write back
// or load the output register; a new request is taken only once the controller is idle again
// fill walks one column byte per cycle
// clear writes the whole store; results leave through an output register
// reset: synchronous; a clearing pass zeroes the store, req_stall stays high
// throughout, the refresh stream restarts at page 0
module mono_lcd_framebuffer_engine import mlfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_col,
   input  logic [7:0] req_row,
   input  logic [7:0] req_col_end,
   input  logic [7:0] req_row_end,
   input  logic       req_pixel_on,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_frame_end,
   output logic       rsp_status
);

   st_type state_ff, state_in;
   op_type op_ff, op_in, req_op;
   logic   status_ff, status_in;

   // fill walk
   logic [COL_W-1:0]  x_ff, x_in, x_end_ff, x_end_in;
   logic [PAGE_W-1:0] g_ff, g_in, g_first_ff, g_first_in, g_last_ff, g_last_in;
   logic [2:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic              on_ff, on_in;

   // write-back stage
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]        wr_mask_ff, wr_mask_in;
   logic              wr_on_ff, wr_on_in;

   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_byte_valid_ff, rsp_byte_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_is_data_ff, rsp_is_data_in;
   logic       rsp_frame_end_ff, rsp_frame_end_in;
   logic       rsp_status_ff, rsp_status_in;

   logic              ram_we, rd_en;
   logic [ADDR_W-1:0] ram_waddr, rd_addr;
   logic [7:0]        ram_wdata, rd_data;
   rfr_type           rfr;
   logic              advance, accept, out_free;

   logic       pt_in_bounds, fill_go;
   logic [7:0] xe, ye;
   logic [2:0] lo_cur, hi_cur;
   logic [7:0] fill_mask;

   assign req_op   = op_type'(req_operation);
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign pt_in_bounds = ({1'b0, req_col} < 9'(COLUMNS)) && ({1'b0, req_row} < 9'(ROWS));
   assign xe = ({1'b0, req_col_end} < 9'(COLUMNS)) ? req_col_end : 8'(COLUMNS - 1);
   assign ye = ({1'b0, req_row_end} < 9'(ROWS)) ? req_row_end : 8'(ROWS - 1);
   assign fill_go = pt_in_bounds && (req_col <= req_col_end) && (req_row <= req_row_end);

   // rows of the current page that the rectangle covers
   assign lo_cur    = (g_ff == g_first_ff) ? lo_ff : 3'd0;
   assign hi_cur    = (g_ff == g_last_ff) ? hi_ff : 3'd7;
   assign fill_mask = (8'hFF >> lo_cur) & (8'hFF << (3'd7 - hi_cur));

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      status_in         = status_ff;
      x_in              = x_ff;
      x_end_in          = x_end_ff;
      g_in              = g_ff;
      g_first_in        = g_first_ff;
      g_last_in         = g_last_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      on_in             = on_ff;
      wr_pend_in        = 1'b0;
      wr_addr_in        = wr_addr_ff;
      wr_mask_in        = wr_mask_ff;
      wr_on_in          = wr_on_ff;
      clr_cnt_in        = clr_cnt_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_byte_valid_in = rsp_byte_valid_ff;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_is_data_in    = rsp_is_data_ff;
      rsp_frame_end_in  = rsp_frame_end_ff;
      rsp_status_in     = rsp_status_ff;
      req_stall         = 1'b1;
      rd_en             = 1'b0;
      rd_addr           = rfr.addr;
      advance           = 1'b0;
      ram_we            = wr_pend_ff;
      ram_waddr         = wr_addr_ff;
      ram_wdata         = wr_on_ff ? (rd_data | wr_mask_ff) : (rd_data & ~wr_mask_ff);

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = ADDR_W'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = (state_ff == ST_INIT) ? ST_IDLE : ST_RESP;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = req_op;
               status_in = 1'b0;
               state_in  = ST_RESP;
               case (req_op)
                  OP_POINT: begin
                     if (pt_in_bounds) begin
                        rd_en      = 1'b1;
                        rd_addr    = mem_addr(COL_W'(req_col), page_of(PAGE_W'(req_row >> 3)));
                        wr_pend_in = 1'b1;
                        wr_addr_in = rd_addr;
                        wr_mask_in = 8'h80 >> req_row[2:0];
                        wr_on_in   = req_pixel_on;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  OP_FILL: begin
                     x_in       = COL_W'(req_col);
                     x_end_in   = COL_W'(xe);
                     g_in       = PAGE_W'(req_row >> 3);
                     g_first_in = PAGE_W'(req_row >> 3);
                     g_last_in  = PAGE_W'(ye >> 3);
                     lo_in      = req_row[2:0];
                     hi_in      = ye[2:0];
                     on_in      = req_pixel_on;
                     if (fill_go) begin
                        state_in = ST_FILL;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     rd_en = rfr.is_data;
                  end
               endcase
            end
         end
         ST_FILL: begin
            // consecutive bytes differ, so a read never meets its own pending write
            rd_en      = 1'b1;
            rd_addr    = mem_addr(x_ff, page_of(g_ff));
            wr_pend_in = 1'b1;
            wr_addr_in = rd_addr;
            wr_mask_in = fill_mask;
            wr_on_in   = on_ff;
            if (g_ff == g_last_ff) begin
               g_in = g_first_ff;
               x_in = COL_W'(x_ff + 1'b1);
               if (x_ff == x_end_ff) begin
                  state_in = ST_RESP;
               end
            end else begin
               g_in = PAGE_W'(g_ff + 1'b1);
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in          = ST_IDLE;
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_byte_valid_in = 1'b0;
               rsp_out_byte_in   = '0;
               rsp_is_data_in    = 1'b0;
               rsp_frame_end_in  = 1'b0;
               if (op_ff == OP_PULL) begin
                  advance           = 1'b1;
                  rsp_byte_valid_in = 1'b1;
                  rsp_out_byte_in   = rfr.is_data ? rd_data : rfr.cmd_byte;
                  rsp_is_data_in    = rfr.is_data;
                  rsp_frame_end_in  = rfr.last;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_cnt_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      status_ff         <= status_in;
      x_ff              <= x_in;
      x_end_ff          <= x_end_in;
      g_ff              <= g_in;
      g_first_ff        <= g_first_in;
      g_last_ff         <= g_last_in;
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      on_ff             <= on_in;
      wr_addr_ff        <= wr_addr_in;
      wr_mask_ff        <= wr_mask_in;
      wr_on_ff          <= wr_on_in;
      rsp_byte_valid_ff <= rsp_byte_valid_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_is_data_ff    <= rsp_is_data_in;
      rsp_frame_end_ff  <= rsp_frame_end_in;
      rsp_status_ff     <= rsp_status_in;
   end

   mlfb_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mlfb_refresh u_refresh (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rfr     (rfr)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_is_data    = rsp_is_data_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;
   assign rsp_status     = rsp_status_ff;

   // the clearing pass owns the write port
   a_no_wb_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_INIT) |-> !wr_pend_ff)
      else $error("write-back pending during clearing pass");

   // read data must hold while the response waits
   a_no_read_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> !rd_en)
      else $error("store read while response pending");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but controller stayed idle");

   a_frame_end_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_is_data && rsp_byte_valid))
      else $error("frame end flagged on a non-data byte");

endmodule

FILE: rtl/core/mlfb_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mlfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mlfb_refresh.sv
// refresh stream position: page and offset counters, command bytes and store address
// depends on mlfb_pkg
module mlfb_refresh import mlfb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   output rfr_type rfr
);

   localparam logic [OFF_W-1:0] OFF_PAGE   = OFF_W'(0);
   localparam logic [OFF_W-1:0] OFF_LO     = OFF_W'(1);
   localparam logic [OFF_W-1:0] OFF_HI     = OFF_W'(2);
   localparam logic [OFF_W-1:0] OFF_DATA   = OFF_W'(3);
   localparam logic [OFF_W-1:0] OFF_END    = OFF_W'(OFF_LAST);
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

   logic [PAGE_W-1:0] page_ff, page_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [COL_W-1:0]  col;

   assign col = COL_W'(off_ff - OFF_DATA);

   always_comb begin
      rfr.addr     = mem_addr(col, page_ff);
      rfr.last     = (page_ff == PAGE_LAST) && (off_ff == OFF_END);
      rfr.is_data  = 1'b0;
      rfr.cmd_byte = CMD_COL_LO;
      case (off_ff)
         OFF_PAGE: rfr.cmd_byte = 8'(CMD_PAGE + 8'(page_ff));
         OFF_LO:   rfr.cmd_byte = CMD_COL_LO;
         OFF_HI:   rfr.cmd_byte = CMD_COL_HI;
         default:  rfr.is_data  = 1'b1;
      endcase
   end

   always_comb begin
      page_in = page_ff;
      off_in  = off_ff;
      if (advance) begin
         if (off_ff == OFF_END) begin
            off_in  = OFF_PAGE;
            page_in = (page_ff == PAGE_LAST) ? '0 : PAGE_W'(page_ff + 1'b1);
         end else begin
            off_in = OFF_W'(off_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         off_ff  <= OFF_PAGE;
      end else begin
         page_ff <= page_in;
         off_ff  <= off_in;
      end
   end

endmodule
